// ===== rtl/oahm_pkg.sv =====
// Shared types and constants for the open-addressing hash map.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package oahm_pkg;

  localparam int SLOTS   = 256;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = 9;

  localparam logic [7:0] TAG_EMPTY   = 8'h80;
  localparam logic [7:0] TAG_DELETED = 8'hFE;
  localparam logic [CNT_W-1:0] MAX_USED_RESET = 9'd192;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [31:0] key_hash;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic            hit;
    logic [63:0]     value_out;
    logic            table_full;
    logic [CNT_W-1:0] live_entries;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic check;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic stop;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/open_addressing_hash_map_top.sv =====
// Open-addressing hash map with linear probing, top level.
// Depends on oahm_pkg, oahm_ctrl and oahm_dp.
//
// Usage: an item (mode, key, key_hash, value) is transferred on the in_ channel
// with valid/ready; exactly one result (hit, value_out, table_full,
// live_entries) is transferred on the out_ channel for each item, in order.
// The limit register max_used_slots is written through cfg_we/cfg_wdata; the
// user writes it only while the block is idle, which the block itself does not enforce.
// Walk: each probed slot takes a registered memory read (S_READ) and then a
// check of the slot (S_CHECK); a walk probes 1 to 256 slots before the
// commit (S_RESOLVE). A clear needs no walk: it goes from S_READ straight to
// S_RESOLVE.
// A new item is accepted once the previous one has been committed to the
// output register; the result may still wait there.
// Reset clears all slots (through per-slot valid bits), both counts and sets
// the limit to 192. No sweep is needed. If the receiver stalls, the result
// holds in the output register and the next item stalls in its final step.
`timescale 1ns / 1ps

module open_addressing_hash_map_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  oahm_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output oahm_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [oahm_pkg::CNT_W-1:0] cfg_wdata
);

  oahm_pkg::cmd_t    cmd;
  oahm_pkg::status_t st;

  oahm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  oahm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

endmodule

// ===== rtl/oahm_ctrl.sv =====
// Controller state machine for the hash map: sequences item load, probe reads,
// probe checks and the final commit. Depends on oahm_pkg.
`timescale 1ns / 1ps

module oahm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  oahm_pkg::status_t st,
  output oahm_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_READ    = 4'b0010,
    S_CHECK   = 4'b0100,
    S_RESOLVE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // A clear needs no walk.
        state_nxt = st.is_clear ? S_RESOLVE : S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (st.stop) begin
          state_nxt = S_RESOLVE;
        end else begin
          cmd.step = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_RESOLVE: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_in_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE) else $error("commit did not return to idle");
  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.commit)) else $error("step and commit together");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> state_r == S_READ) else $error("load did not start a probe");

endmodule

// ===== rtl/oahm_dp.sv =====
// Datapath for the hash map: slot memories, tag valid bits, walk registers,
// counters, the limit register and the output register. Depends on oahm_pkg.
`timescale 1ns / 1ps

module oahm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  oahm_pkg::cmd_t               cmd,
  input  oahm_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic [oahm_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                         out_ready,
  output logic                         out_valid,
  output oahm_pkg::out_item_t          out_data,
  output oahm_pkg::status_t            st
);

  localparam int IW = oahm_pkg::IDX_W;
  localparam int CW = oahm_pkg::CNT_W;

  logic [7:0]  tag_mem [oahm_pkg::SLOTS];
  logic [63:0] key_mem [oahm_pkg::SLOTS];
  logic [63:0] val_mem [oahm_pkg::SLOTS];
  logic [oahm_pkg::SLOTS-1:0] valid_r;

  logic [7:0]  tag_rd_r;
  logic [63:0] key_rd_r, val_rd_r;
  logic        vld_rd_r;

  oahm_pkg::in_item_t  item_r;
  oahm_pkg::out_item_t out_r;
  logic          out_valid_r;
  logic [IW-1:0] idx_r, cnt_r;
  logic          found_r, tomb_v_r, empty_v_r;
  logic [IW-1:0] found_idx_r, tomb_idx_r, empty_idx_r;
  logic [63:0]   vout_r;
  logic [CW-1:0] live_r, used_r, max_r;

  logic [7:0] tag_cur, item_tag;
  logic       p_empty, p_tomb, p_match;

  assign item_tag = {1'b0, item_r.key_hash[31:25]};
  assign tag_cur  = vld_rd_r ? tag_rd_r : oahm_pkg::TAG_EMPTY;
  assign p_empty  = (tag_cur == oahm_pkg::TAG_EMPTY);
  assign p_tomb   = (tag_cur == oahm_pkg::TAG_DELETED);
  assign p_match  = (tag_cur == item_tag) && (key_rd_r == item_r.key);

  assign st.is_clear = (item_r.mode == oahm_pkg::MODE_CLEAR);
  assign st.stop     = p_empty || p_match || (cnt_r == IW'(oahm_pkg::SLOTS - 1));
  assign st.out_free = !out_valid_r || out_ready;

  // Commit decisions.
  logic          room, ins_tomb, ins_empty, ins_full, wr_en, tag_wr;
  logic [IW-1:0] wr_idx;
  logic [7:0]    wr_tag;
  logic [63:0]   wr_key, wr_val;

  always_comb begin
    room      = ({1'b0, used_r} + 10'd1) <= {1'b0, max_r};
    ins_tomb  = !found_r && tomb_v_r;
    ins_empty = !found_r && !tomb_v_r && empty_v_r && room;
    ins_full  = !found_r && !ins_tomb && !ins_empty;
    wr_en     = 1'b0;
    tag_wr    = 1'b0;
    wr_idx    = found_idx_r;
    wr_tag    = item_tag;
    wr_key    = item_r.key;
    wr_val    = item_r.value;
    if (cmd.commit) begin
      case (item_r.mode)
        oahm_pkg::MODE_INSERT: begin
          if (found_r) begin
            wr_en = 1'b1;
          end else if (ins_tomb || ins_empty) begin
            wr_en  = 1'b1;
            tag_wr = 1'b1;
            wr_idx = ins_tomb ? tomb_idx_r : empty_idx_r;
          end
        end
        oahm_pkg::MODE_REMOVE: begin
          // Key and value of a tombstone are never read again.
          if (found_r) begin
            tag_wr = 1'b1;
            wr_tag = oahm_pkg::TAG_DELETED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tag_wr) tag_mem[wr_idx] <= wr_tag;
    if (tag_wr && item_r.mode == oahm_pkg::MODE_INSERT) key_mem[wr_idx] <= wr_key;
    if (wr_en) val_mem[wr_idx] <= wr_val;
    tag_rd_r <= tag_mem[idx_r];
    key_rd_r <= key_mem[idx_r];
    val_rd_r <= val_mem[idx_r];
    vld_rd_r <= valid_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r    <= in_data;
      idx_r     <= in_data.key_hash[IW-1:0];
      cnt_r     <= '0;
      found_r   <= 1'b0;
      tomb_v_r  <= 1'b0;
      empty_v_r <= 1'b0;
      vout_r    <= '0;
    end
    if (cmd.check) begin
      if (p_empty) begin
        empty_v_r   <= 1'b1;
        empty_idx_r <= idx_r;
      end else if (p_tomb) begin
        if (!tomb_v_r) begin
          tomb_v_r   <= 1'b1;
          tomb_idx_r <= idx_r;
        end
      end else if (p_match) begin
        found_r     <= 1'b1;
        found_idx_r <= idx_r;
        vout_r      <= val_rd_r;
      end
    end
    if (cmd.step) begin
      idx_r <= idx_r + IW'(1);
      cnt_r <= cnt_r + IW'(1);
    end
    if (cmd.commit) begin
      out_r.hit        <= found_r && !st.is_clear;
      out_r.value_out  <= (found_r && item_r.mode == oahm_pkg::MODE_LOOKUP) ? vout_r : '0;
      out_r.table_full <= (item_r.mode == oahm_pkg::MODE_INSERT) && ins_full;
      case (item_r.mode)
        oahm_pkg::MODE_INSERT:
          out_r.live_entries <= (ins_tomb || ins_empty) ? live_r + CW'(1) : live_r;
        oahm_pkg::MODE_REMOVE:
          out_r.live_entries <= (found_r && live_r != '0) ? live_r - CW'(1) : live_r;
        oahm_pkg::MODE_CLEAR:
          out_r.live_entries <= '0;
        default:
          out_r.live_entries <= live_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      live_r      <= '0;
      used_r      <= '0;
      max_r       <= oahm_pkg::MAX_USED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (tag_wr) valid_r[wr_idx] <= 1'b1;
        case (item_r.mode)
          oahm_pkg::MODE_INSERT: begin
            if (ins_tomb || ins_empty) live_r <= live_r + CW'(1);
            if (ins_empty) used_r <= used_r + CW'(1);
          end
          oahm_pkg::MODE_REMOVE: begin
            if (found_r && live_r != '0) live_r <= live_r - CW'(1);
          end
          oahm_pkg::MODE_CLEAR: begin
            valid_r <= '0;
            live_r  <= '0;
            used_r  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= used_r) else $error("live count above used count");
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && item_r.mode == oahm_pkg::MODE_CLEAR |=> live_r == '0 && used_r == '0)
    else $error("clear left counts nonzero");
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.table_full |-> !out_r.hit) else $error("refused insert with hit");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r || out_ready) else $error("result overwritten");

endmodule

// ===== bench/tb_open_addressing_hash_map_top.sv =====
// Self-checking testbench for open_addressing_hash_map_top.
// Depends on oahm_pkg and the RTL; drives a directed table, a fill-to-capacity pass,
// then random traffic, and checks every result against typed expectations or an in-bench table model.
`timescale 1ns / 1ps

module tb_open_addressing_hash_map_top;

  typedef struct {
    bit                  is_cfg;
    bit [8:0]            cfg_val;
    oahm_pkg::in_item_t  item;
    bit                  typed;
    oahm_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  oahm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  oahm_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [oahm_pkg::CNT_W-1:0] cfg_wdata = '0;

  // Shadow copy of the table.
  logic [7:0]  shadow_tag [oahm_pkg::SLOTS];
  logic [63:0] shadow_key [oahm_pkg::SLOTS];
  logic [63:0] shadow_val [oahm_pkg::SLOTS];
  int unsigned live_cnt, used_cnt, load_limit;

  oahm_pkg::out_item_t pending_results [$];
  dir_row_t  dir_rows [$];
  logic [63:0] pool_key [64];
  logic [31:0] pool_hash [64];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned fail_cnt, sent_cnt, hit_cnt, full_cnt, got_cnt;

  open_addressing_hash_map_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic oahm_pkg::out_item_t map_apply(oahm_pkg::in_item_t it);
    oahm_pkg::out_item_t r;
    int idx, found, tomb, empty, dest;
    logic [7:0] tag;
    r = '0;
    if (it.mode == oahm_pkg::MODE_CLEAR) begin
      for (int i = 0; i < oahm_pkg::SLOTS; i++) shadow_tag[i] = oahm_pkg::TAG_EMPTY;
      live_cnt = 0;
      used_cnt = 0;
    end else begin
      idx = it.key_hash % oahm_pkg::SLOTS;
      tag = {1'b0, it.key_hash[31:25]};
      found = -1;
      tomb = -1;
      empty = -1;
      for (int n = 0; n < oahm_pkg::SLOTS; n++) begin
        if (shadow_tag[idx] == oahm_pkg::TAG_EMPTY) begin
          empty = idx;
          break;
        end
        if (shadow_tag[idx] == oahm_pkg::TAG_DELETED) begin
          if (tomb < 0) tomb = idx;
        end else if (shadow_tag[idx] == tag && shadow_key[idx] == it.key) begin
          found = idx;
          break;
        end
        idx = (idx + 1) % oahm_pkg::SLOTS;
      end
      if (found >= 0) r.hit = 1'b1;
      if (it.mode == oahm_pkg::MODE_LOOKUP) begin
        if (found >= 0) r.value_out = shadow_val[found];
      end else if (it.mode == oahm_pkg::MODE_REMOVE) begin
        if (found >= 0) begin
          shadow_tag[found] = oahm_pkg::TAG_DELETED;
          shadow_key[found] = '0;
          shadow_val[found] = '0;
          if (live_cnt > 0) live_cnt--;
        end
      end else begin
        dest = -1;
        if (found >= 0) shadow_val[found] = it.value;
        else if (tomb >= 0) dest = tomb;
        else if (empty >= 0 && used_cnt + 1 <= load_limit) begin
          dest = empty;
          used_cnt++;
        end else r.table_full = 1'b1;
        if (dest >= 0) begin
          shadow_tag[dest] = tag;
          shadow_key[dest] = it.key;
          shadow_val[dest] = it.value;
          live_cnt++;
        end
      end
    end
    r.live_entries = live_cnt[8:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // Send one item; the caller always resumes right after a rising edge.
  // Valid stays high after the transfer until the next call or drain() lowers
  // it or replaces the payload in the same time step.
  task automatic send_item(oahm_pkg::in_item_t it, bit typed = 1'b0,
                           oahm_pkg::out_item_t want = '0);
    oahm_pkg::out_item_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pred = map_apply(it);
    pending_results.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    // The block is idle by the time the last result clears; the settle is extra margin.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [8:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_limit = v;
  endtask

  function automatic oahm_pkg::in_item_t mk(logic [1:0] m, logic [63:0] k, logic [31:0] h,
                                            logic [63:0] v);
    oahm_pkg::in_item_t it;
    it.mode = m;
    it.key = k;
    it.key_hash = h;
    it.value = v;
    return it;
  endfunction

  function automatic void add_row(bit is_cfg, logic [8:0] cv, oahm_pkg::in_item_t it,
                                  bit typed, logic h, logic [63:0] vo, logic f,
                                  logic [8:0] le);
    dir_row_t r;
    r.is_cfg = is_cfg;
    r.cfg_val = cv;
    r.item = it;
    r.typed = typed;
    r.want.hit = h;
    r.want.value_out = vo;
    r.want.table_full = f;
    r.want.live_entries = le;
    dir_rows.push_back(r);
  endfunction

  function automatic oahm_pkg::in_item_t rand_item();
    oahm_pkg::in_item_t it;
    int p, roll;
    p = $urandom_range(0, 63);
    roll = $urandom_range(0, 99);
    it.key = pool_key[p];
    it.key_hash = pool_hash[p];
    // Mostly pooled keys so that hits and collisions are common.
    if (roll < 8) begin
      it.key = {$urandom, $urandom};
      it.key_hash = $urandom;
    end else if (roll < 12) begin
      it.key_hash = $urandom;
    end
    roll = $urandom_range(0, 99);
    if (roll < 42) it.mode = oahm_pkg::MODE_INSERT;
    else if (roll < 72) it.mode = oahm_pkg::MODE_LOOKUP;
    else if (roll < 98) it.mode = oahm_pkg::MODE_REMOVE;
    else it.mode = oahm_pkg::MODE_CLEAR;
    it.value = {$urandom, $urandom};
    return it;
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    oahm_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      got_cnt++;
      if (pending_results.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.hit != exp_r.hit)
          report($sformatf("hit %0b, expected %0b", out_data.hit, exp_r.hit));
        if (out_data.value_out != exp_r.value_out)
          report($sformatf("value_out %h, expected %h", out_data.value_out,
                           exp_r.value_out));
        if (out_data.table_full != exp_r.table_full)
          report($sformatf("table_full %0b, expected %0b", out_data.table_full,
                           exp_r.table_full));
        if (out_data.live_entries != exp_r.live_entries)
          report($sformatf("live_entries %0d, expected %0d", out_data.live_entries,
                           exp_r.live_entries));
        if (exp_r.hit) hit_cnt++;
        if (exp_r.table_full) full_cnt++;
      end
    end
  end

  initial begin
    for (int i = 0; i < oahm_pkg::SLOTS; i++) begin
      shadow_tag[i] = oahm_pkg::TAG_EMPTY;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    live_cnt = 0;
    used_cnt = 0;
    load_limit = oahm_pkg::MAX_USED_RESET;
    for (int i = 0; i < 64; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = {7'($urandom_range(0, 127)), 17'($urandom),
                      8'($urandom_range(0, 95))};
      // Every fourth key shares hash and tag with its neighbor.
      if (i % 4 == 3) pool_hash[i] = pool_hash[i - 1];
    end
    send_idle_pct = 38;
    recv_idle_pct = 45;

    // Directed rows; typed expectations only where they are obvious.
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, '1, '1, '1), 1, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, '1, '1, '1), 1, 0, 0, 0, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, '1, '1, '0), 1, 1, '1, 0, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, '1, '1, 64'h5A5A), 1, 1, 0, 0, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, '1, '1, '0), 1, 1, 64'h5A5A, 0, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, '0, '0, '0), 1, 0, 0, 0, 2);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, '0, '0, '1), 1, 1, 0, 0, 2);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, '1, 32'h0000_00FE, '0), 1, 0, 0, 0, 2);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, '1, 32'h0000_00FF, 64'h77), 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'h1234, 32'hFE00_00FF, 64'h88),
            0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_REMOVE, '1, '1, '0), 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_REMOVE, '1, '1, '0), 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, 64'h1234, 32'hFE00_00FF, '0), 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'h9999, 32'h0200_00FF, 64'h99),
            0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, 64'h9999, 32'h0200_00FF, '0), 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_CLEAR, '1, '1, '1), 1, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_LOOKUP, '0, '0, '0), 1, 0, 0, 0, 0);
    add_row(1, 9'd1, '0, 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'hA, 32'h10, 64'h1), 1, 0, 0, 0, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'hB, 32'h20, 64'h2), 1, 0, 0, 1, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'hA, 32'h10, 64'h3), 1, 1, 0, 0, 1);
    add_row(0, 0, mk(oahm_pkg::MODE_REMOVE, 64'hA, 32'h10, '0), 1, 1, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'hB, 32'h10, 64'h4), 1, 0, 0, 0, 1);
    add_row(1, 9'd0, '0, 0, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_CLEAR, '0, '0, '0), 1, 0, 0, 0, 0);
    add_row(0, 0, mk(oahm_pkg::MODE_INSERT, 64'hC, 32'h30, 64'h5), 1, 0, 0, 1, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_limit(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    // Fill every slot from one start point so chains wrap, then one more key.
    write_limit(9'd256);
    send_item(mk(oahm_pkg::MODE_CLEAR, '0, '0, '0));
    for (int i = 0; i <= oahm_pkg::SLOTS; i++)
      send_item(mk(oahm_pkg::MODE_INSERT, 64'hF111_0000_0000_0000 + i,
                   {7'(i), 17'($urandom), 8'hF0}, {$urandom, $urandom}));
    send_item(mk(oahm_pkg::MODE_REMOVE, 64'hF111_0000_0000_0005, '0, '0));
    send_item(mk(oahm_pkg::MODE_CLEAR, '0, '0, '0));

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 45;
        recv_idle_pct = 38;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(9'd0);
        for (int i = 0; i < 30; i++) send_item(rand_item());
      end
      write_limit(ph == 1 ? 9'd256 : 9'($urandom_range(24, 192)));
      for (int i = 0; i < 412; i++) begin
        if (i == 206) drain();
        send_item(rand_item());
      end
    end

    drain();
    repeat (600) @(posedge clk);
    $display("Covered %0d items: %0d hits, %0d refused inserts, %0d results checked.",
             sent_cnt, hit_cnt, full_cnt, got_cnt);
    $display("Load limits from zero to full table, with wrapped chains and tombstones.");
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
